### hw/rtl/tld_pkg.sv
// Package for the tty line discipline: codes, control word layout and the microcode table.
package tld_pkg;

    // Microcode address and entry points of the routines.
    typedef logic [4:0] t_upc;
    localparam t_upc UA_IDLE      = 5'd0;
    localparam t_upc UA_CTRL_C    = 5'd1;
    localparam t_upc UA_INTR      = 5'd4;
    localparam t_upc UA_BACKSPACE = 5'd5;
    localparam t_upc UA_NL_LOOP   = 5'd9;
    localparam t_upc UA_NL_TAIL   = 5'd10;
    localparam t_upc UA_PUSH      = 5'd12;
    localparam t_upc UA_RAW_CTRL  = 5'd14;
    localparam t_upc UA_RAW_CHAR  = 5'd15;
    localparam t_upc UA_ESC       = 5'd17;

    // Key classes.
    localparam logic [3:0] KEY_OTHER    = 4'd0;
    localparam logic [3:0] KEY_END      = 4'd7;
    localparam logic [3:0] KEY_LETTER_C = 4'd8;
    localparam logic [2:0] KEY_UP       = 3'd1;
    localparam logic [2:0] KEY_DOWN     = 3'd2;
    localparam logic [2:0] KEY_LEFT     = 3'd3;
    localparam logic [2:0] KEY_RIGHT    = 3'd4;
    localparam logic [2:0] KEY_DELETE   = 3'd5;
    localparam logic [2:0] KEY_HOME     = 3'd6;
    localparam logic [2:0] KEY_ENDNAV   = 3'd7;

    // Configuration register indexes.
    localparam logic CFG_CANONICAL = 1'b0;
    localparam logic CFG_ECHO      = 1'b1;

    // Character constants.
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_CTRL_MASK = 8'h1F;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_UPPER_C   = 8'h43;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_TILDE     = 8'h7E;

    typedef enum logic [1:0] {
        KIND_READER = 2'd0,
        KIND_ECHO   = 2'd1,
        KIND_INTR   = 2'd2
    } t_kind;

    // Condition under which a step is skipped and control jumps.
    typedef enum logic [1:0] {
        SK_NONE    = 2'd0,
        SK_NOECHO  = 2'd1,
        SK_PTR_END = 2'd2,
        SK_NOTDEL  = 2'd3
    } t_skip;

    // Source of the emitted byte.
    typedef enum logic [2:0] {
        SRC_CONST     = 3'd0,
        SRC_CHAR      = 3'd1,
        SRC_CTRL_CHAR = 3'd2,
        SRC_STORE     = 3'd3,
        SRC_ESC       = 3'd4
    } t_src;

    // Action on the line store.
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_CLEAR = 3'd1,
        ACT_DEC   = 3'd2,
        ACT_PUSH  = 3'd3,
        ACT_ADV   = 3'd4
    } t_act;

    typedef enum logic [1:0] {
        NX_INC  = 2'd0,
        NX_STAY = 2'd1,
        NX_IDLE = 2'd2
    } t_next;

    // How the last-of-run flag of an emitted item is formed.
    typedef enum logic [1:0] {
        LAST_NO     = 2'd0,
        LAST_YES    = 2'd1,
        LAST_NOECHO = 2'd2,
        LAST_NOTDEL = 2'd3
    } t_last;

    typedef struct packed {
        t_skip      skip;
        t_upc       skip_to;
        logic       emit;
        t_kind      kind;
        t_src       src;
        logic [7:0] cbyte;
        t_last      last;
        t_act       act;
        t_next      nxt;
    } t_uword;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic       exec;
        logic       emit;
        t_act       act;
        t_kind      kind;
        t_src       src;
        logic [7:0] cbyte;
        t_last      last;
    } t_seq_ctl;

    // Status from the line store to the sequencer.
    typedef struct packed {
        logic ptr_end;
        logic len_zero;
        logic len_full;
    } t_store_stat;

    function automatic t_uword uw(input t_skip skip, input t_upc skip_to, input logic emit,
                                  input t_kind kind, input t_src src, input logic [7:0] cbyte,
                                  input t_last last, input t_act act, input t_next nxt);
        t_uword w;
        w.skip    = skip;
        w.skip_to = skip_to;
        w.emit    = emit;
        w.kind    = kind;
        w.src     = src;
        w.cbyte   = cbyte;
        w.last    = last;
        w.act     = act;
        w.nxt     = nxt;
        return w;
    endfunction

    // The microprogram.
    function automatic t_uword ucode(input t_upc a);
        t_uword w;
        w = uw(SK_NONE, UA_IDLE, 1'b0, KIND_READER, SRC_CONST, CH_NUL, LAST_NO, ACT_NONE,
               NX_IDLE);
        unique case (a)
            // Ctrl+C: optional echo of the caret sequence, then the interrupt request.
            5'd1:  w = uw(SK_NOECHO, UA_INTR, 1'b1, KIND_ECHO, SRC_CONST, CH_CARET, LAST_NO,
                          ACT_NONE, NX_INC);
            5'd2:  w = uw(SK_NOECHO, UA_INTR, 1'b1, KIND_ECHO, SRC_CONST, CH_UPPER_C, LAST_NO,
                          ACT_NONE, NX_INC);
            5'd3:  w = uw(SK_NOECHO, UA_INTR, 1'b1, KIND_ECHO, SRC_CONST, CH_LF, LAST_NO,
                          ACT_NONE, NX_INC);
            5'd4:  w = uw(SK_NONE, UA_IDLE, 1'b1, KIND_INTR, SRC_CONST, CH_NUL, LAST_YES,
                          ACT_CLEAR, NX_IDLE);
            // Backspace: shorten the line, then echo the erase sequence.
            5'd5:  w = uw(SK_NONE, UA_IDLE, 1'b0, KIND_READER, SRC_CONST, CH_NUL, LAST_NO,
                          ACT_DEC, NX_INC);
            5'd6:  w = uw(SK_NOECHO, UA_IDLE, 1'b1, KIND_ECHO, SRC_CONST, CH_BS, LAST_NO,
                          ACT_NONE, NX_INC);
            5'd7:  w = uw(SK_NONE, UA_IDLE, 1'b1, KIND_ECHO, SRC_CONST, CH_SPACE, LAST_NO,
                          ACT_NONE, NX_INC);
            5'd8:  w = uw(SK_NONE, UA_IDLE, 1'b1, KIND_ECHO, SRC_CONST, CH_BS, LAST_YES,
                          ACT_NONE, NX_IDLE);
            // Newline: release the stored line, the newline, then its echo.
            5'd9:  w = uw(SK_PTR_END, UA_NL_TAIL, 1'b1, KIND_READER, SRC_STORE, CH_NUL,
                          LAST_NO, ACT_ADV, NX_STAY);
            5'd10: w = uw(SK_NONE, UA_IDLE, 1'b1, KIND_READER, SRC_CONST, CH_LF, LAST_NOECHO,
                          ACT_CLEAR, NX_INC);
            5'd11: w = uw(SK_NOECHO, UA_IDLE, 1'b1, KIND_ECHO, SRC_CONST, CH_LF, LAST_YES,
                          ACT_NONE, NX_IDLE);
            // Canonical plain character: store it, then echo it.
            5'd12: w = uw(SK_NONE, UA_IDLE, 1'b0, KIND_READER, SRC_CONST, CH_NUL, LAST_NO,
                          ACT_PUSH, NX_INC);
            5'd13: w = uw(SK_NOECHO, UA_IDLE, 1'b1, KIND_ECHO, SRC_CHAR, CH_NUL, LAST_YES,
                          ACT_NONE, NX_IDLE);
            // Raw control character.
            5'd14: w = uw(SK_NONE, UA_IDLE, 1'b1, KIND_READER, SRC_CTRL_CHAR, CH_NUL, LAST_YES,
                          ACT_NONE, NX_IDLE);
            // Raw plain character and its echo.
            5'd15: w = uw(SK_NONE, UA_IDLE, 1'b1, KIND_READER, SRC_CHAR, CH_NUL, LAST_NOECHO,
                          ACT_NONE, NX_INC);
            5'd16: w = uw(SK_NOECHO, UA_IDLE, 1'b1, KIND_ECHO, SRC_CHAR, CH_NUL, LAST_YES,
                          ACT_NONE, NX_IDLE);
            // Raw navigation key: escape sequence, with a trailing tilde for delete.
            5'd17: w = uw(SK_NONE, UA_IDLE, 1'b1, KIND_READER, SRC_CONST, CH_ESC, LAST_NO,
                          ACT_NONE, NX_INC);
            5'd18: w = uw(SK_NONE, UA_IDLE, 1'b1, KIND_READER, SRC_CONST, CH_LBRACKET, LAST_NO,
                          ACT_NONE, NX_INC);
            5'd19: w = uw(SK_NONE, UA_IDLE, 1'b1, KIND_READER, SRC_ESC, CH_NUL, LAST_NOTDEL,
                          ACT_NONE, NX_INC);
            5'd20: w = uw(SK_NOTDEL, UA_IDLE, 1'b1, KIND_READER, SRC_CONST, CH_TILDE, LAST_YES,
                          ACT_NONE, NX_IDLE);
            default: ;
        endcase
        return w;
    endfunction

    // Final byte of the escape sequence for each navigation key.
    function automatic logic [7:0] esc_final(input logic [2:0] cls);
        logic [7:0] b;
        unique case (cls)
            KEY_UP:     b = 8'h41;
            KEY_DOWN:   b = 8'h42;
            KEY_LEFT:   b = 8'h44;
            KEY_RIGHT:  b = 8'h43;
            KEY_DELETE: b = 8'h33;
            KEY_HOME:   b = 8'h48;
            KEY_ENDNAV: b = 8'h46;
            default:    b = CH_NUL;
        endcase
        return b;
    endfunction

endpackage

### hw/rtl/tld_line_store.sv
// Line store of the tty line discipline: byte memory, line length and read pointer.
module tld_line_store import tld_pkg::*; #(
    parameter int LINE_DEPTH = 62
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_seq_ctl    i_ctl,
    input  logic [7:0]  i_char,
    output logic [7:0]  o_rd_data,
    output t_store_stat o_stat
);

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int LW = $clog2(LINE_DEPTH + 1);
    localparam logic [LW-1:0] LEN_FULL = LW'(LINE_DEPTH);

    logic [7:0]    r_mem [LINE_DEPTH];
    logic [7:0]    r_rd_data;
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic [LW-1:0] r_ptr;
    logic [LW-1:0] n_ptr;

    // Next line length from the current step's action.
    always_comb begin
        n_len = r_len;
        if (i_ctl.exec) begin
            unique case (i_ctl.act)
                ACT_CLEAR: n_len = '0;
                ACT_DEC:   n_len = r_len - LW'(1);
                ACT_PUSH:  n_len = r_len + LW'(1);
                default:   n_len = r_len;
            endcase
        end
    end

    // The read pointer restarts with each item and advances while the line is released.
    always_comb begin
        n_ptr = r_ptr;
        if (i_start) begin
            n_ptr = '0;
        end else if (i_ctl.exec && i_ctl.act == ACT_ADV) begin
            n_ptr = r_ptr + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ptr <= '0;
        end else begin
            r_len <= n_len;
            r_ptr <= n_ptr;
        end
    end

    // Memory: one write port at the line end, one registered read at the next pointer.
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && i_ctl.act == ACT_PUSH) begin
            r_mem[r_len[AW-1:0]] <= i_char;
        end
        r_rd_data <= r_mem[n_ptr[AW-1:0]];
    end

    assign o_rd_data       = r_rd_data;
    assign o_stat.ptr_end  = (r_ptr == r_len);
    assign o_stat.len_zero = (r_len == '0);
    assign o_stat.len_full = (r_len == LEN_FULL);

endmodule

### hw/rtl/tld_sequencer.sv
// Microcode sequencer of the tty line discipline: dispatch, step counter and jump logic.
module tld_sequencer import tld_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [3:0]  i_key_class,
    input  logic [7:0]  i_char_code,
    input  logic        i_ctrl_held,
    input  logic        i_key_release,
    input  logic        i_canonical,
    input  logic        i_echo,
    input  logic        i_is_delete,
    input  logic        i_out_free,
    input  t_store_stat i_stat,
    output logic        o_idle,
    output t_seq_ctl    o_ctl
);

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword w;
    logic   skip;
    logic   stall;
    logic   exec;

    // Entry point of the routine for a newly accepted key event.
    function automatic t_upc dispatch(input logic [3:0] cls_in, input logic [7:0] ch,
                                      input logic ctrl, input logic rel, input logic canon,
                                      input t_store_stat st);
        logic [3:0] cls;
        logic       nav;
        t_upc       a;
        cls = (cls_in > KEY_LETTER_C) ? KEY_OTHER : cls_in;
        nav = (cls != KEY_OTHER) && (cls <= KEY_END);
        a   = UA_IDLE;
        priority if (rel) begin
            a = UA_IDLE;
        end else if (ctrl && cls == KEY_LETTER_C) begin
            a = UA_CTRL_C;
        end else if (canon) begin
            priority if (nav || ch == CH_NUL) begin
                a = UA_IDLE;
            end else if (ch == CH_BS) begin
                a = st.len_zero ? UA_IDLE : UA_BACKSPACE;
            end else if (ch == CH_LF) begin
                a = UA_NL_LOOP;
            end else if (!ctrl && !st.len_full) begin
                a = UA_PUSH;
            end else begin
                a = UA_IDLE;
            end
        end else begin
            priority if (nav) begin
                a = UA_ESC;
            end else if (ch == CH_NUL) begin
                a = UA_IDLE;
            end else if (ctrl) begin
                a = UA_RAW_CTRL;
            end else begin
                a = UA_RAW_CHAR;
            end
        end
        return a;
    endfunction

    assign w      = ucode(r_pc);
    assign o_idle = (r_pc == UA_IDLE);

    // Skip condition of the current step.
    always_comb begin
        unique case (w.skip)
            SK_NONE:    skip = 1'b0;
            SK_NOECHO:  skip = !i_echo;
            SK_PTR_END: skip = i_stat.ptr_end;
            SK_NOTDEL:  skip = !i_is_delete;
            default:    skip = 1'b0;
        endcase
        skip = skip && !o_idle;
    end

    // A step that emits waits for room in the output register.
    assign stall = !o_idle && !skip && w.emit && !i_out_free;
    assign exec  = !o_idle && !skip && !stall;

    // Step counter.
    always_comb begin
        n_pc = r_pc;
        priority if (i_accept) begin
            n_pc = dispatch(i_key_class, i_char_code, i_ctrl_held, i_key_release,
                            i_canonical, i_stat);
        end else if (skip) begin
            n_pc = w.skip_to;
        end else if (exec) begin
            unique case (w.nxt)
                NX_INC:  n_pc = r_pc + 5'd1;
                NX_STAY: n_pc = r_pc;
                default: n_pc = UA_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UA_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl.exec  = exec;
    assign o_ctl.emit  = exec && w.emit;
    assign o_ctl.act   = w.act;
    assign o_ctl.kind  = w.kind;
    assign o_ctl.src   = w.src;
    assign o_ctl.cbyte = w.cbyte;
    assign o_ctl.last  = w.last;

endmodule

### hw/rtl/tty_line_discipline.sv
// Top level of the tty line discipline: configuration, input capture and output register.
//
// Key events enter on the s_axis channel: tdata carries the character, tuser the key
// class, the control modifier and the release flag. Results leave on the m_axis
// channel: tdata is the byte, tuser the kind (reader, echo, interrupt), and tlast
// marks the final result of one key event. Configuration must be written through the
// plain write port only while no key event is in progress; the block does not enforce this.
// A microprogram handles each event one at a time; tready is low while it runs.
// Dispatch happens in the acceptance cycle; each microcode step then emits at most one
// result into the output register, and a skipped step emits none. A release or a dropped
// key starts no routine and leaves the sequencer idle.
// When the receiver stalls, the step that emits waits and the program holds.
// Reset empties the line and selects canonical mode with echo on.
module tty_line_discipline import tld_pkg::*; #(
    parameter int LINE_DEPTH = 62
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Key events.
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_code
    input  logic [5:0] i_s_axis_tuser,   // [3:0] key_class, [4] ctrl_held, [5] key_release
    // Results.
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_axis_tuser,   // [1:0] out_kind
    output logic       o_m_axis_tlast,   // last_of_run
    // Configuration writes.
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic       i_cfg_data
);

    logic        r_canonical;
    logic        r_echo;
    logic [7:0]  r_char;
    logic [2:0]  r_cls;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [1:0]  r_out_kind;
    logic        r_out_last;
    logic        accept;
    logic        idle;
    logic        out_free;
    logic        is_delete;
    logic [7:0]  rd_data;
    logic [7:0]  n_byte;
    logic        n_last;
    t_seq_ctl    ctl;
    t_store_stat stat;

    assign o_s_axis_tready = idle;
    assign accept          = i_s_axis_tvalid && idle;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign is_delete       = (r_cls == KEY_DELETE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canonical <= 1'b1;
            r_echo      <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CANONICAL: r_canonical <= i_cfg_data;
                CFG_ECHO:      r_echo      <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Fields of the accepted item that the program uses later.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_s_axis_tdata;
            r_cls  <= i_s_axis_tuser[2:0];
        end
    end

    tld_sequencer u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_key_class   (i_s_axis_tuser[3:0]),
        .i_char_code   (i_s_axis_tdata),
        .i_ctrl_held   (i_s_axis_tuser[4]),
        .i_key_release (i_s_axis_tuser[5]),
        .i_canonical   (r_canonical),
        .i_echo        (r_echo),
        .i_is_delete   (is_delete),
        .i_out_free    (out_free),
        .i_stat        (stat),
        .o_idle        (idle),
        .o_ctl         (ctl)
    );

    tld_line_store #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_ctl     (ctl),
        .i_char    (r_char),
        .o_rd_data (rd_data),
        .o_stat    (stat)
    );

    // Byte and end-of-run flag of the emitted item.
    always_comb begin
        unique case (ctl.src)
            SRC_CONST:     n_byte = ctl.cbyte;
            SRC_CHAR:      n_byte = r_char;
            SRC_CTRL_CHAR: n_byte = r_char & CH_CTRL_MASK;
            SRC_STORE:     n_byte = rd_data;
            SRC_ESC:       n_byte = esc_final(r_cls);
            default:       n_byte = ctl.cbyte;
        endcase
        unique case (ctl.last)
            LAST_NO:     n_last = 1'b0;
            LAST_YES:    n_last = 1'b1;
            LAST_NOECHO: n_last = !r_echo;
            LAST_NOTDEL: n_last = !is_delete;
            default:     n_last = 1'b0;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit) begin
            r_out_byte <= n_byte;
            r_out_kind <= ctl.kind;
            r_out_last <= n_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    // A result is only loaded when the output register has room.
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.emit |-> out_free)
        else $error("result emitted into an occupied output register");

    // An interrupt request carries a zero byte and closes its run.
    a_intr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_INTR |-> o_m_axis_tlast &&
        o_m_axis_tdata == CH_NUL)
        else $error("interrupt result malformed");

    // A release event is dropped at once.
    a_release_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_s_axis_tuser[5] |=> o_s_axis_tready)
        else $error("release event kept the sequencer busy");

    // A Ctrl+C press, not a release, always starts a routine.
    a_ctrl_c_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_s_axis_tuser[5] && i_s_axis_tuser[4] &&
        i_s_axis_tuser[3:0] == KEY_LETTER_C |=> !o_s_axis_tready)
        else $error("Ctrl+C not handled");

    // The line store never grows past its depth.
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.exec && ctl.act == ACT_PUSH |-> !stat.len_full)
        else $error("character pushed into a full line");

endmodule

### dv/tb_tty_line_discipline.sv
// Self-checking testbench for the tty line discipline, with its own line editing predictor.
`timescale 1ns / 100ps

module tb_tty_line_discipline;
    import tld_pkg::*;

    localparam int LINE_DEPTH   = 62;
    localparam int CLS_MAX      = 15;
    localparam int DRAIN_CYCLES = 12;
    localparam int TAIL_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 1000000;

    // Key classes as they travel in the low bits of the input tuser.
    typedef enum logic [3:0] {
        KC_OTHER    = 4'd0,
        KC_UP       = 4'd1,
        KC_DOWN     = 4'd2,
        KC_LEFT     = 4'd3,
        KC_RIGHT    = 4'd4,
        KC_DELETE   = 4'd5,
        KC_HOME     = 4'd6,
        KC_END      = 4'd7,
        KC_LETTER_C = 4'd8
    } t_key_cls;

    typedef struct packed {
        logic       rel;
        logic       ctrl;
        logic [3:0] cls;
        logic [7:0] ch;
    } t_key;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Stimulus side.
    logic key_valid = 1'b0;
    t_key key_item  = '0;
    logic out_ready = 1'b1;
    logic cfg_we    = 1'b0;
    logic cfg_idx   = 1'b0;
    logic cfg_data  = 1'b0;

    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic [1:0] o_m_axis_tuser;
    logic       o_m_axis_tlast;

    // Predictor state: our own copy of the line and the registers.
    logic [7:0] line_buf [LINE_DEPTH];
    int         line_len;
    logic       canon_on;
    logic       echo_on;
    t_result    key_run[$];
    t_result    tty_out_pending[$];

    int      mismatch_count = 0;
    int      keys_sent = 0;
    int      cycle_count = 0;
    int      stall_left = 0;
    bit      sender_idle_on = 1'b0;
    bit      receiver_idle_on = 1'b0;
    t_result want;

    tty_line_discipline #(
        .LINE_DEPTH(LINE_DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (key_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (key_item.ch),
        .i_s_axis_tuser  ({key_item.rel, key_item.ctrl, key_item.cls}),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    // Clock with a 2 ns period.
    always #1 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // While enabled, the receiver drops ready in stall bursts that start at random.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Compare every accepted result item with the oldest one predicted.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && out_ready) begin
            if (tty_out_pending.size() == 0) begin
                report_mismatch($sformatf("unexpected item kind %0d byte %02h last %0b",
                                          o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                want = tty_out_pending.pop_front();
                if (o_m_axis_tuser !== want.kind)
                    report_mismatch($sformatf("kind %0d, predicted %0d",
                                              o_m_axis_tuser, want.kind));
                if (o_m_axis_tdata !== want.data)
                    report_mismatch($sformatf("byte %02h, predicted %02h",
                                              o_m_axis_tdata, want.data));
                if (o_m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last flag %0b, predicted %0b",
                                              o_m_axis_tlast, want.last));
            end
        end
    end

    function automatic void push_run(input t_kind kind, input logic [7:0] b);
        t_result r;
        r.kind = kind;
        r.data = b;
        r.last = 1'b0;
        key_run = {key_run, r};
    endfunction

    // Final byte of the escape sequence sent for a navigation key in raw mode.
    function automatic logic [7:0] nav_final_byte(input logic [3:0] cls);
        case (cls)
            KC_UP:     return "A";
            KC_DOWN:   return "B";
            KC_LEFT:   return "D";
            KC_RIGHT:  return "C";
            KC_DELETE: return "3";
            KC_HOME:   return "H";
            KC_END:    return "F";
            default:   return CH_NUL;
        endcase
    endfunction

    // Work out the results of one accepted key event and queue them in order.
    function automatic void predict_tty_output(input t_key k);
        logic [3:0] cls;
        logic       is_nav;
        key_run.delete();
        if (k.rel)
            return;
        cls = (k.cls > KC_LETTER_C) ? KC_OTHER : k.cls;
        is_nav = (cls >= KC_UP) && (cls <= KC_END);

        if (k.ctrl && cls == KC_LETTER_C) begin
            // Interrupt: caret echo when enabled, line dropped in either mode.
            if (echo_on) begin
                push_run(KIND_ECHO, CH_CARET);
                push_run(KIND_ECHO, CH_UPPER_C);
                push_run(KIND_ECHO, CH_LF);
            end
            line_len = 0;
            push_run(KIND_INTR, CH_NUL);
        end else if (canon_on) begin
            if (is_nav || k.ch == CH_NUL) begin
                // Navigation keys and empty characters are dropped when editing.
            end else if (k.ch == CH_BS) begin
                if (line_len > 0) begin
                    line_len--;
                    if (echo_on) begin
                        push_run(KIND_ECHO, CH_BS);
                        push_run(KIND_ECHO, CH_SPACE);
                        push_run(KIND_ECHO, CH_BS);
                    end
                end
            end else if (k.ch == CH_LF) begin
                for (int i = 0; i < line_len; i++)
                    push_run(KIND_READER, line_buf[i]);
                push_run(KIND_READER, CH_LF);
                line_len = 0;
                if (echo_on)
                    push_run(KIND_ECHO, CH_LF);
            end else if (!k.ctrl && line_len < LINE_DEPTH) begin
                line_buf[line_len] = k.ch;
                line_len++;
                if (echo_on)
                    push_run(KIND_ECHO, k.ch);
            end
        end else begin
            if (is_nav) begin
                push_run(KIND_READER, CH_ESC);
                push_run(KIND_READER, CH_LBRACKET);
                push_run(KIND_READER, nav_final_byte(cls));
                if (cls == KC_DELETE)
                    push_run(KIND_READER, CH_TILDE);
            end else if (k.ch != CH_NUL) begin
                if (k.ctrl) begin
                    push_run(KIND_READER, k.ch & CH_CTRL_MASK);
                end else begin
                    push_run(KIND_READER, k.ch);
                    if (echo_on)
                        push_run(KIND_ECHO, k.ch);
                end
            end
        end

        if (key_run.size() > 0)
            key_run[key_run.size() - 1].last = 1'b1;
        foreach (key_run[i])
            tty_out_pending = {tty_out_pending, key_run[i]};
    endfunction

    function automatic t_key make_key(input logic [3:0] cls, input logic [7:0] ch,
                                      input logic ctrl, input logic rel);
        t_key k;
        k.cls  = cls;
        k.ch   = ch;
        k.ctrl = ctrl;
        k.rel  = rel;
        return k;
    endfunction

    function automatic t_key plain_key(input logic [7:0] ch);
        return make_key(KC_OTHER, ch, 1'b0, 1'b0);
    endfunction

    // Any event the fields allow, releases and unused classes included.
    function automatic t_key noise_key();
        return make_key(4'($urandom_range(0, CLS_MAX)), 8'($urandom_range(0, 255)),
                        $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0);
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    // Offer one item and wait until it is accepted; an optional idle burst goes first.
    task automatic send_key(input t_key k);
        int gap;
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            repeat (gap) begin
                @(negedge i_clk);
                key_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        key_valid <= 1'b1;
        key_item  <= k;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_tty_output(k);
        if (!k.rel)
            keys_sent++;
    endtask

    // Hold off the sender until every predicted item has come out and the block is idle.
    task automatic wait_drained();
        @(negedge i_clk);
        key_valid <= 1'b0;
        while (tty_out_pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic idx, input logic val);
        wait_drained();
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CANONICAL)
            canon_on = val;
        else
            echo_on = val;
    endtask

    task automatic pick_idling();
        sender_idle_on   = $urandom_range(0, 3) != 0;
        receiver_idle_on = $urandom_range(0, 3) != 0;
    endtask

    // A typed line with random edits and noise, usually closed by a newline.
    task automatic send_random_line();
        int n;
        int r;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 66) : $urandom_range(0, 10);
        repeat (n) begin
            r = $urandom_range(0, 19);
            if (r < 2)
                send_key(make_key(KC_OTHER, CH_BS, 1'($urandom_range(0, 1)), 1'b0));
            else if (r == 2)
                send_key(noise_key());
            else if (r == 3)
                send_key(make_key(KC_OTHER, printable(), 1'b0, 1'b1));
            else if (r == 4)
                send_key(plain_key(8'($urandom_range(1, 255))));
            else
                send_key(plain_key(printable()));
        end
        r = $urandom_range(0, 9);
        if (r == 0)
            send_key(make_key(KC_LETTER_C, "c", 1'b1, 1'b0));
        else if (r != 1)
            send_key(make_key(KC_OTHER, CH_LF, 1'($urandom_range(0, 1)), 1'b0));
    endtask

    task automatic send_random_raw_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            send_key(make_key(4'($urandom_range(KC_UP, KC_END)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'b0));
        else if (r < 4)
            send_key(make_key(KC_OTHER, 8'($urandom_range(1, 255)), 1'b1, 1'b0));
        else if (r < 7)
            send_key(plain_key(8'($urandom_range(1, 255))));
        else if (r == 7)
            send_key(make_key(KC_LETTER_C, "c", 1'b1, 1'b0));
        else
            send_key(noise_key());
    endtask

    // Line editing: storing, erasing, releasing, dropped keys and the interrupt.
    task automatic test_canonical_editing();
        set_config(CFG_CANONICAL, 1'b1);
        set_config(CFG_ECHO, 1'b1);
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        send_key(plain_key("a"));
        send_key(plain_key(8'hFF));
        send_key(make_key(KC_OTHER, "z", 1'b0, 1'b1));
        for (int c = KC_UP; c <= KC_END; c++)
            send_key(make_key(c[3:0], "n", 1'b0, 1'b0));
        send_key(make_key(4'(CLS_MAX), "x", 1'b0, 1'b0));
        send_key(make_key(KC_LETTER_C, "c", 1'b0, 1'b0));
        send_key(plain_key(CH_NUL));
        send_key(make_key(KC_OTHER, "a", 1'b1, 1'b0));
        send_key(make_key(KC_OTHER, CH_BS, 1'b1, 1'b0));
        send_key(plain_key(CH_BS));
        send_key(plain_key(CH_LF));
        send_key(plain_key(CH_BS));
        send_key(plain_key("q"));
        send_key(make_key(KC_OTHER, CH_LF, 1'b1, 1'b0));
        send_key(plain_key("w"));
        send_key(make_key(KC_LETTER_C, "c", 1'b1, 1'b0));
        send_key(plain_key(CH_LF));
    endtask

    // Raw mode: escape sequences, masked control characters, echo on and off.
    task automatic test_raw_keys();
        set_config(CFG_CANONICAL, 1'b0);
        for (int c = KC_UP; c <= KC_END; c++)
            send_key(make_key(c[3:0], CH_NUL, c[0], 1'b0));
        send_key(make_key(KC_OTHER, "a", 1'b1, 1'b0));
        send_key(make_key(KC_OTHER, 8'hFF, 1'b1, 1'b0));
        send_key(plain_key("k"));
        send_key(plain_key(CH_NUL));
        send_key(make_key(4'(CLS_MAX), CH_NUL, 1'b0, 1'b0));
        send_key(make_key(4'(KC_LETTER_C + 1), "y", 1'b0, 1'b0));
        send_key(make_key(KC_LETTER_C, "c", 1'b1, 1'b0));
        set_config(CFG_ECHO, 1'b0);
        send_key(plain_key("m"));
        send_key(make_key(KC_OTHER, CH_BS, 1'b1, 1'b0));
        send_key(make_key(KC_LETTER_C, "c", 1'b1, 1'b0));
    endtask

    // A full line store drops further characters; a full newline gives the longest run.
    task automatic test_full_line();
        set_config(CFG_CANONICAL, 1'b1);
        set_config(CFG_ECHO, 1'b1);
        pick_idling();
        repeat (LINE_DEPTH + 2)
            send_key(plain_key(printable()));
        send_key(plain_key(CH_LF));
        set_config(CFG_ECHO, 1'b0);
        repeat (LINE_DEPTH + 1)
            send_key(plain_key(printable()));
        send_key(plain_key(CH_BS));
        send_key(plain_key(CH_LF));
    endtask

    // The sender stops until every predicted item has come out, then carries on.
    task automatic test_sender_pause();
        set_config(CFG_ECHO, 1'b1);
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        send_random_line();
        wait_drained();
        send_random_line();
    endtask

    task automatic test_random_canonical();
        int target;
        set_config(CFG_CANONICAL, 1'b1);
        for (int chunk = 0; chunk < 3; chunk++) begin
            set_config(CFG_ECHO, (chunk == 1) ? 1'b0 : 1'($urandom_range(0, 1)));
            pick_idling();
            target = keys_sent + 6;
            while (keys_sent < target) begin
                send_random_line();
                if ($urandom_range(0, 7) == 0)
                    wait_drained();
            end
        end
    endtask

    task automatic test_random_raw();
        int target;
        set_config(CFG_CANONICAL, 1'b0);
        for (int chunk = 0; chunk < 2; chunk++) begin
            set_config(CFG_ECHO, chunk == 0);
            pick_idling();
            target = keys_sent + 10;
            while (keys_sent < target)
                send_random_raw_key();
        end
    endtask

    // Last stretch without any idling on either side.
    task automatic test_tail_no_idling();
        int target;
        set_config(CFG_CANONICAL, 1'($urandom_range(0, 1)));
        set_config(CFG_ECHO, 1'($urandom_range(0, 1)));
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        target = keys_sent + 12;
        while (keys_sent < target) begin
            if (canon_on)
                send_random_line();
            else
                send_random_raw_key();
        end
    endtask

    initial begin
        line_len = 0;
        canon_on = 1'b1;
        echo_on  = 1'b1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_canonical_editing();
        test_raw_keys();
        test_full_line();
        test_sender_pause();
        test_random_canonical();
        test_random_raw();
        test_tail_no_idling();

        // Let everything drain, then allow time for any stray item to show up.
        @(negedge i_clk);
        key_valid <= 1'b0;
        while (tty_out_pending.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tty_out_pending.size() != 0)
            report_mismatch($sformatf("%0d predicted items never came out",
                                      tty_out_pending.size()));
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
hw/rtl/tld_pkg.sv
hw/rtl/tld_line_store.sv
hw/rtl/tld_sequencer.sv
hw/rtl/tty_line_discipline.sv
dv/tb_tty_line_discipline.sv
